### sv/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants for the congruence solver
// Item structs, status codes and the front-to-back job record.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int MAX_PAIRS    = 4;
  localparam int MODULUS_BITS = 16;
  localparam int IDX_W        = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CNT_W        = $clog2(MAX_PAIRS + 1);
  localparam int QDEPTH       = 2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOCOPR   = 2'd1;
  localparam logic [1:0] ST_ZERO_MOD = 2'd2;
  localparam logic [1:0] ST_TOO_MANY = 2'd3;

  typedef struct packed {
    logic [15:0] remainder;
    logic [15:0] modulus;
    logic        last_pair;
  } crt_in_t;

  typedef struct packed {
    logic [63:0] solution;
    logic [1:0]  status;
  } crt_out_t;

  typedef struct packed {
    logic [MAX_PAIRS-1:0][15:0] rems;
    logic [MAX_PAIRS-1:0][15:0] mods;
    logic [CNT_W-1:0]           count;
    logic [1:0]                 status;
  } crt_job_t;

endpackage

### sv/crt_congruence_solver.sv
// ----------------------------------------------------------------------------
// crt_congruence_solver: Chinese remainder theorem solver
// Collects up to four congruence pairs and solves the system on the last one.
// ----------------------------------------------------------------------------
// A pair is transferred when start is high and busy low. On a pair marked
// last_pair the closed system goes to a two-entry queue and the back engine
// solves it: first the product of the moduli, then per pair 64-bit serial
// division, extended Euclid steps and shift-add multiply, all on one shared
// bit-serial divider and shift-add multiplier. The result appears for one
// cycle with done high and cannot be held off; busy is high while the queue
// is full and for the cycle after a last pair.
module crt_congruence_solver (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  crt_pkg::crt_in_t  item,
  output logic              done,
  output crt_pkg::crt_out_t result
);
  import crt_pkg::*;

  logic take, fv, q_ne, q_full, pop;
  crt_job_t fjob, qhead;

  assign take = start && !busy;
  assign busy = q_full || fv;

  crt_front u_front (.clk, .rst, .take, .item, .job_valid(fv), .job(fjob));
  crt_queue u_queue (.clk, .rst, .push(fv), .push_data(fjob), .pop,
                     .not_empty(q_ne), .full(q_full), .head(qhead));
  crt_back  u_back  (.clk, .rst, .job_valid(q_ne), .job(qhead), .job_pop(pop),
                     .res_valid(done), .res(result));

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !fv) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_ne) else $error("pop from empty queue");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.solution == 64'd0)
    else $error("error result carries a solution");
endmodule

### sv/crt_front.sv
// ----------------------------------------------------------------------------
// crt_front: pair collection
// Stores pairs, flags overflow and zero moduli, issues a job on the last pair.
// ----------------------------------------------------------------------------
module crt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  crt_pkg::crt_in_t  item,
  output logic              job_valid,
  output crt_pkg::crt_job_t job
);
  import crt_pkg::*;

  logic [MAX_PAIRS-1:0][15:0] rems, mods;
  logic [CNT_W-1:0] pair_count;
  logic overflow_flag;
  logic [MAX_PAIRS-1:0][15:0] rems_next, mods_next;
  logic [CNT_W-1:0] count_next;
  logic ovf_next;
  logic [15:0] rem_m, mod_m;
  logic zero_any;

  assign rem_m = item.remainder & 16'((32'd1 << MODULUS_BITS) - 1);
  assign mod_m = item.modulus & 16'((32'd1 << MODULUS_BITS) - 1);

  always_comb begin
    rems_next  = rems;
    mods_next  = mods;
    count_next = pair_count;
    ovf_next   = overflow_flag;
    if (pair_count < CNT_W'(MAX_PAIRS)) begin
      rems_next[pair_count[IDX_W-1:0]] = rem_m;
      mods_next[pair_count[IDX_W-1:0]] = mod_m;
      count_next = pair_count + 1'b1;
    end else begin
      ovf_next = 1'b1;
    end
    zero_any = 1'b0;
    for (int i = 0; i < MAX_PAIRS; i++)
      if (CNT_W'(i) < count_next && mods_next[i] == 16'd0) zero_any = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rems <= rems_next;
      mods <= mods_next;
      job.rems  <= rems_next;
      job.mods  <= mods_next;
      job.count <= count_next;
      job.status <= ovf_next ? ST_TOO_MANY : (zero_any ? ST_ZERO_MOD : ST_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count    <= '0;
      overflow_flag <= 1'b0;
      job_valid     <= 1'b0;
    end else begin
      job_valid <= take && item.last_pair;
      if (take) begin
        if (item.last_pair) begin
          pair_count    <= '0;
          overflow_flag <= 1'b0;
        end else begin
          pair_count    <= count_next;
          overflow_flag <= ovf_next;
        end
      end
    end
  end
endmodule

### sv/crt_queue.sv
// ----------------------------------------------------------------------------
// crt_queue: job queue
// Small FIFO of closed systems between collection and solving.
// ----------------------------------------------------------------------------
module crt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crt_pkg::crt_job_t push_data,
  input  logic              pop,
  output logic              not_empty,
  output logic              full,
  output crt_pkg::crt_job_t head
);
  import crt_pkg::*;

  crt_job_t mem [QDEPTH];
  logic [0:0] wp, rp;
  logic [1:0] fill;

  assign not_empty = fill != 2'd0;
  assign full      = fill == 2'(QDEPTH);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### sv/crt_back.sv
// ----------------------------------------------------------------------------
// crt_back: CRT engine
// Product, per-pair division, extended Euclid and modular multiply, all bit
// serial on one shared divider and a shift-add multiplier.
// ----------------------------------------------------------------------------
module crt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  crt_pkg::crt_job_t job,
  output logic              job_pop,
  output logic              res_valid,
  output crt_pkg::crt_out_t res
);
  import crt_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001, S_PROD = 11'b00000000010, S_MUL  = 11'b00000000100,
    S_MI   = 11'b00000001000, S_DIV  = 11'b00000010000, S_EUC  = 11'b00000100000,
    S_EUCD = 11'b00001000000, S_COEF = 11'b00010000000, S_CMUL = 11'b00100000000,
    S_TERM = 11'b01000000000, S_DONE = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    D_MI = 3'b001, D_AMOD = 3'b010, D_EUC = 3'b100
  } dsel_t;

  typedef enum logic [2:0] {
    M_PROD = 3'b001, M_COEF = 3'b010, M_TERM = 3'b100
  } msel_t;

  state_t state;
  dsel_t  dsel;
  msel_t  msel;
  crt_job_t jb;
  logic [IDX_W:0] idx;
  logic [63:0] prod, sum, mi;
  logic tmp;
  logic [15:0] m;
  // divider
  logic [63:0] dq, dr, dd;
  logic [6:0]  dcnt;
  logic [64:0] dtrial;
  // multiplier
  logic [63:0] ma, macc;
  logic [63:0] mb;
  logic [6:0]  mcnt;
  // euclid
  logic [16:0] r0, r1;
  logic signed [17:0] s0, s1;
  logic [15:0] inv;
  logic [63:0] term, gap;
  logic signed [18:0] sv;

  assign dtrial = {1'b0, dr[62:0], dq[63]} - {1'b0, dd};
  assign gap = prod - term;
  // final Bezout coefficient lies within +/- m
  assign sv = (s0 < 0) ? 19'(s0) + $signed({3'b000, m}) : 19'(s0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job_pop   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      job_pop   <= 1'b0;
      res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid && !job_pop) begin
            jb <= job;
            job_pop <= 1'b1;
            prod <= 64'd1;
            sum <= 64'd0;
            idx <= '0;
            state <= (job.status == ST_OK) ? S_PROD : S_DONE;
          end
        end
        S_PROD: begin
          if (idx == jb.count) begin
            idx <= '0;
            state <= S_MI;
          end else begin
            ma <= prod;
            mb <= {48'd0, jb.mods[idx[IDX_W-1:0]]};
            macc <= '0;
            mcnt <= 7'd0;
            msel <= M_PROD;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mcnt == 7'd64) begin
            case (msel)
              M_PROD: begin
                prod <= macc;
                idx <= idx + 1'b1;
                state <= S_PROD;
              end
              M_COEF: begin
                dq <= macc;
                dr <= '0;
                dd <= {48'd0, m};
                dcnt <= 7'd0;
                dsel <= D_MI;
                tmp <= 1'b1;
                state <= S_DIV;
              end
              M_TERM: begin
                term <= macc;
                state <= S_TERM;
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            if (mb[0]) macc <= macc + ma;
            ma <= ma << 1;
            mb <= mb >> 1;
            mcnt <= mcnt + 1'b1;
          end
        end
        S_MI: begin
          if (idx == jb.count) begin
            state <= S_DONE;
          end else begin
            m <= jb.mods[idx[IDX_W-1:0]];
            dq <= prod;
            dr <= '0;
            dd <= {48'd0, jb.mods[idx[IDX_W-1:0]]};
            dcnt <= 7'd0;
            dsel <= D_MI;
            tmp <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == 7'd64) begin
            case (dsel)
              D_MI: begin
                if (tmp) begin
                  ma <= mi;
                  mb <= {48'd0, dr[15:0]};
                  macc <= '0;
                  mcnt <= 7'd0;
                  msel <= M_TERM;
                  state <= S_MUL;
                end else begin
                  mi <= dq;
                  dq <= dq;
                  dd <= {48'd0, m};
                  dr <= '0;
                  dcnt <= 7'd0;
                  dsel <= D_AMOD;
                  state <= S_DIV;
                end
              end
              D_AMOD: begin
                r0 <= {1'b0, dr[15:0]};
                r1 <= {1'b0, m};
                s0 <= 18'sd1;
                s1 <= 18'sd0;
                state <= S_EUC;
              end
              D_EUC: begin
                r0 <= r1;
                r1 <= dr[16:0];
                s0 <= s1;
                s1 <= s0 - $signed(dq[17:0]) * s1;
                state <= S_EUC;
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            if (!dtrial[64]) begin
              dr <= dtrial[63:0];
              dq <= {dq[62:0], 1'b1};
            end else begin
              dr <= {dr[62:0], dq[63]};
              dq <= {dq[62:0], 1'b0};
            end
            dcnt <= dcnt + 1'b1;
          end
        end
        S_EUC: begin
          if (r1 == 17'd0) begin
            state <= S_EUCD;
          end else begin
            dq <= {47'd0, r0};
            dr <= '0;
            dd <= {47'd0, r1};
            dcnt <= 7'd0;
            dsel <= D_EUC;
            state <= S_DIV;
          end
        end
        S_EUCD: begin
          if (r0 != 17'd1) begin
            jb.status <= ST_NOCOPR;
            state <= S_DONE;
          end else begin
            inv <= (sv >= $signed({3'b000, m})) ? 16'(sv - $signed({3'b000, m}))
                                                : sv[15:0];
            state <= S_COEF;
          end
        end
        S_COEF: begin
          ma <= {48'd0, jb.rems[idx[IDX_W-1:0]]};
          mb <= {48'd0, inv};
          macc <= '0;
          mcnt <= 7'd0;
          msel <= M_COEF;
          state <= S_MUL;
        end
        S_TERM: begin
          if (sum >= gap) sum <= sum - gap;
          else sum <= sum + term;
          idx <= idx + 1'b1;
          state <= S_MI;
        end
        S_DONE: begin
          res_valid <= 1'b1;
          res.status <= jb.status;
          res.solution <= (jb.status == ST_OK) ? sum : 64'd0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/crt_congruence_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_congruence_solver_tb: self-checking bench for the congruence solver
// Sends congruence systems through the start/busy handshake, predicts each
// solution and status, and compares every done strobe with the oldest one.
// ----------------------------------------------------------------------------
module crt_congruence_solver_tb;
  import crt_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  crt_in_t  item;
  logic     done;
  crt_out_t result;

  crt_out_t    solutions_q[$];
  logic [15:0] sys_rems[MAX_PAIRS];
  logic [15:0] sys_mods[MAX_PAIRS];
  int          sys_count;
  bit          sys_overflow;
  int          errors;
  int          idle_cycles;

  crt_congruence_solver u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // modular inverse of a mod m by extended Euclid; returns 0 when not coprime
  function automatic bit mod_inverse(input longint a, input longint m,
                                     output longint inv);
    longint r0, r1, s0, s1, q, t;
    r0 = a; r1 = m; s0 = 1; s1 = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1; r0 = r1; r1 = t;
      t = s0 - q * s1; s0 = s1; s1 = t;
    end
    inv = s0 % m;
    if (inv < 0) inv += m;
    return r0 == 1;
  endfunction

  function automatic crt_out_t solve_system();
    crt_out_t    r;
    logic [63:0] prod, sum, m, mi, coef, term;
    longint      inv;
    r.solution = '0;
    r.status   = ST_OK;
    if (sys_overflow) r.status = ST_TOO_MANY;
    else for (int i = 0; i < sys_count; i++)
      if (sys_mods[i] == 0) r.status = ST_ZERO_MOD;
    if (r.status == ST_OK) begin
      prod = 1; sum = 0;
      for (int i = 0; i < sys_count; i++) prod = prod * sys_mods[i];
      for (int i = 0; i < sys_count; i++) begin
        m  = sys_mods[i];
        mi = prod / m;
        if (!mod_inverse(longint'(mi % m), longint'(m), inv)) begin
          r.status = ST_NOCOPR;
          break;
        end
        coef = ((64'(sys_rems[i]) % m) * 64'(inv)) % m;
        term = mi * coef;
        if (sum >= prod - term) sum -= prod - term;
        else sum += term;
      end
      if (r.status == ST_OK) r.solution = sum;
    end
    return r;
  endfunction

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_pair(input logic [15:0] rem, input logic [15:0] mdl,
                           input bit last);
    random_gap();
    start <= 1'b1;
    item  <= '{remainder: rem, modulus: mdl, last_pair: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (sys_count < MAX_PAIRS) begin
      sys_rems[sys_count] = rem;
      sys_mods[sys_count] = mdl;
      sys_count++;
    end else sys_overflow = 1'b1;
    if (last) begin
      solutions_q.push_back(solve_system());
      sys_count    = 0;
      sys_overflow = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    crt_out_t exp_r;
    if (!rst && done) begin
      if (solutions_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        exp_r = solutions_q.pop_front();
        if (result.solution !== exp_r.solution || result.status !== exp_r.status) begin
          $display("%0t: mismatch expected sol=%0d st=%0d actual sol=%0d st=%0d",
                   $time, exp_r.solution, exp_r.status, result.solution, result.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] small_prime();
    logic [15:0] primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 251, 257, 65521};
    return primes[$urandom_range(0, 11)];
  endfunction

  task automatic test_directed();
    send_pair(16'd2, 16'd3, 0); send_pair(16'd3, 16'd5, 0);
    send_pair(16'd2, 16'd7, 1);
    send_pair(16'hFFFF, 16'hFFFF, 1);
    send_pair(16'hFFFF, 16'd65521, 0); send_pair(16'h0000, 16'hFFFF, 1);
    send_pair(16'd9, 16'd4, 0); send_pair(16'd5, 16'd1, 1);
    send_pair(16'd1, 16'd4, 0); send_pair(16'd1, 16'd6, 1);
    send_pair(16'd1, 16'd0, 0); send_pair(16'd1, 16'd6, 1);
    send_pair(16'd1, 16'd4, 0); send_pair(16'd1, 16'd0, 1);
    send_pair(16'd1, 16'd0, 0); send_pair(16'd1, 16'd3, 0); send_pair(16'd1, 16'd5, 0);
    send_pair(16'd1, 16'd7, 0); send_pair(16'd1, 16'd11, 1);
    send_pair(16'hFFFF, 16'd65521, 0); send_pair(16'hAAAA, 16'd65519, 0);
    send_pair(16'h5555, 16'd65497, 0); send_pair(16'h1234, 16'd65479, 1);
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    while (solutions_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic test_random();
    int n, sent, kind;
    sent = 0;
    while (sent < 1000) begin
      kind = $urandom_range(0, 9);
      n = (kind == 0) ? $urandom_range(5, 7) : $urandom_range(1, MAX_PAIRS);
      for (int i = 0; i < n; i++) begin
        logic [15:0] r, m;
        r = 16'($urandom);
        case (kind)
          1, 2:    m = 16'($urandom);
          3:       m = 16'($urandom_range(0, 3));
          default: m = small_prime();
        endcase
        if (kind > 3 && $urandom_range(0, 1)) r = r % (m == 0 ? 1 : m);
        send_pair(r, m, i == n - 1);
        sent++;
      end
    end
  endtask

  initial begin
    errors      = 0;
    sys_count   = 0;
    sys_overflow = 1'b0;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random();
    test_drain_pause();
    if (errors == 0 && solutions_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
